// File: design/assert_macros.svh
// assertion helpers used by the parser core
// the checks drop out entirely when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: design/fsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_pkg
// Types, codes and saturating arithmetic for the FASTA statistics parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int LENGTH_BITS = 40;
    localparam int COUNT_BITS  = 32;
    localparam int PHASE_BITS  = 3;

    localparam logic [LENGTH_BITS-1:0] LONG_THRESHOLD_RESET = LENGTH_BITS'(10000);

    // input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_EOF    = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_MISSING_MARK  = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR      = 2'd1;
    localparam logic [1:0] ERR_EOF_IN_HEADER = 2'd2;

    // parser phases
    localparam logic [PHASE_BITS-1:0] PH_MARK     = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_HEADER   = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_SEQ      = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_AFTER_LF = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_DONE     = 3'd4;
    localparam logic [PHASE_BITS-1:0] PH_ERROR    = 3'd5;

    // characters
    localparam logic [7:0] CH_MARK = 8'h3E;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_T_UP = 8'h54;
    localparam logic [7:0] CH_T_LO = 8'h74;
    localparam logic [7:0] CH_C_UP = 8'h43;
    localparam logic [7:0] CH_C_LO = 8'h63;
    localparam logic [7:0] CH_G_UP = 8'h47;
    localparam logic [7:0] CH_G_LO = 8'h67;
    localparam logic [7:0] CH_N_UP = 8'h4E;
    localparam logic [7:0] CH_N_LO = 8'h6E;

    // byte classes inside a sequence line
    localparam logic [2:0] CLS_AT    = 3'd0;
    localparam logic [2:0] CLS_GC    = 3'd1;
    localparam logic [2:0] CLS_N     = 3'd2;
    localparam logic [2:0] CLS_CR    = 3'd3;
    localparam logic [2:0] CLS_LF    = 3'd4;
    localparam logic [2:0] CLS_OTHER = 3'd5;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } fsp_item_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [1:0]             error_code;
        logic [LENGTH_BITS-1:0] record_length;
        logic [LENGTH_BITS-1:0] total_length;
        logic [LENGTH_BITS-1:0] long_total_length;
        logic [COUNT_BITS-1:0]  record_count;
        logic [COUNT_BITS-1:0]  long_record_count;
        logic [LENGTH_BITS-1:0] largest_record;
        logic [LENGTH_BITS-1:0] at_total;
        logic [LENGTH_BITS-1:0] gc_total;
        logic [LENGTH_BITS-1:0] n_total;
    } fsp_result_t;

    function automatic logic [2:0] classify(input logic [7:0] c);
        logic [2:0] cls;
        case (c) inside
            CH_A_UP, CH_A_LO, CH_T_UP, CH_T_LO: cls = CLS_AT;
            CH_C_UP, CH_C_LO, CH_G_UP, CH_G_LO: cls = CLS_GC;
            CH_N_UP, CH_N_LO:                   cls = CLS_N;
            CH_CR:                              cls = CLS_CR;
            CH_LF:                              cls = CLS_LF;
            default:                            cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_add_len(
        input logic [LENGTH_BITS-1:0] a,
        input logic [LENGTH_BITS-1:0] b
    );
        logic [LENGTH_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_inc_len(input logic [LENGTH_BITS-1:0] a);
        return (&a) ? a : a + LENGTH_BITS'(1);
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc_cnt(input logic [COUNT_BITS-1:0] a);
        return (&a) ? a : a + COUNT_BITS'(1);
    endfunction

endpackage

// File: design/fsp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_in_stage
// Input register: holds one accepted word until the parser core takes it.
// ----------------------------------------------------------------------------
module fsp_in_stage
    import fsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  fsp_item_t item_in,
    input  logic      take,
    output logic      item_valid,
    output fsp_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    fsp_item_t item_reg;

    // room when empty or when the held word leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tvalid ? 1'b1 : (valid_reg && !take);

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= s_tready ? valid_next : valid_reg;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: design/fsp_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// fsp_core
// Parser state and running totals; one word is processed per advance.
// ----------------------------------------------------------------------------
module fsp_core
    import fsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  fsp_item_t              item,
    input  logic [LENGTH_BITS-1:0] long_threshold,
    output logic                   res_valid,
    output fsp_result_t            result
);

    logic [PHASE_BITS-1:0]  phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] cur_len_reg, cur_len_next;
    logic [LENGTH_BITS-1:0] len_sum_reg, len_sum_next;
    logic [LENGTH_BITS-1:0] long_sum_reg, long_sum_next;
    logic [COUNT_BITS-1:0]  rec_cnt_reg, rec_cnt_next;
    logic [COUNT_BITS-1:0]  long_cnt_reg, long_cnt_next;
    logic [LENGTH_BITS-1:0] largest_reg, largest_next;
    logic [LENGTH_BITS-1:0] at_reg, at_next;
    logic [LENGTH_BITS-1:0] gc_reg, gc_next;
    logic [LENGTH_BITS-1:0] n_reg, n_next;

    logic       is_eof;
    logic [2:0] cls;
    logic       is_long;
    logic [1:0] kind;
    logic [1:0] err;
    logic       emit;
    logic       use_seq;
    logic       terminal;

    assign is_eof  = (item.op == OP_EOF);
    assign cls     = classify(item.data_byte);
    assign is_long = (cur_len_reg > long_threshold);

    // next state for one word
    always_comb
    begin
        phase_next    = phase_reg;
        cur_len_next  = cur_len_reg;
        len_sum_next  = len_sum_reg;
        long_sum_next = long_sum_reg;
        rec_cnt_next  = rec_cnt_reg;
        long_cnt_next = long_cnt_reg;
        largest_next  = largest_reg;
        at_next       = at_reg;
        gc_next       = gc_reg;
        n_next        = n_reg;
        emit          = 1'b0;
        kind          = KIND_RECORD;
        err           = ERR_MISSING_MARK;
        use_seq       = 1'b0;

        unique case (phase_reg)
            PH_MARK:
            begin
                if (is_eof || item.data_byte != CH_MARK)
                begin
                    phase_next = PH_ERROR;
                    emit       = 1'b1;
                    kind       = KIND_ERROR;
                    err        = ERR_MISSING_MARK;
                end
                else
                begin
                    phase_next = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                if (is_eof)
                begin
                    phase_next = PH_ERROR;
                    emit       = 1'b1;
                    kind       = KIND_ERROR;
                    err        = ERR_EOF_IN_HEADER;
                end
                else if (item.data_byte == CH_LF)
                begin
                    cur_len_next = '0;
                    phase_next   = PH_SEQ;
                end
            end
            PH_SEQ:
            begin
                if (is_eof)
                begin
                    phase_next = PH_ERROR;
                    emit       = 1'b1;
                    kind       = KIND_ERROR;
                    err        = ERR_BAD_CHAR;
                end
                else
                begin
                    use_seq = 1'b1;
                end
            end
            PH_AFTER_LF:
            begin
                if (is_eof || item.data_byte == CH_MARK)
                begin
                    // record closes
                    len_sum_next = sat_add_len(len_sum_reg, cur_len_reg);
                    rec_cnt_next = sat_inc_cnt(rec_cnt_reg);
                    largest_next = (cur_len_reg > largest_reg) ? cur_len_reg : largest_reg;
                    if (is_long)
                    begin
                        long_sum_next = sat_add_len(long_sum_reg, cur_len_reg);
                        long_cnt_next = sat_inc_cnt(long_cnt_reg);
                    end
                    emit       = 1'b1;
                    kind       = is_eof ? KIND_EOF : KIND_RECORD;
                    phase_next = is_eof ? PH_DONE : PH_HEADER;
                end
                else
                begin
                    use_seq = 1'b1;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // byte inside a sequence line
        if (use_seq)
        begin
            case (cls)
                CLS_CR:
                begin
                    phase_next = PH_SEQ;
                end
                CLS_LF:
                begin
                    phase_next = PH_AFTER_LF;
                end
                CLS_AT:
                begin
                    at_next      = sat_inc_len(at_reg);
                    cur_len_next = sat_inc_len(cur_len_reg);
                    phase_next   = PH_SEQ;
                end
                CLS_GC:
                begin
                    gc_next      = sat_inc_len(gc_reg);
                    cur_len_next = sat_inc_len(cur_len_reg);
                    phase_next   = PH_SEQ;
                end
                CLS_N:
                begin
                    n_next       = sat_inc_len(n_reg);
                    cur_len_next = sat_inc_len(cur_len_reg);
                    phase_next   = PH_SEQ;
                end
                default:
                begin
                    phase_next = PH_ERROR;
                    emit       = 1'b1;
                    kind       = KIND_ERROR;
                    err        = ERR_BAD_CHAR;
                end
            endcase
        end
    end

    // result word, totals after this byte
    always_comb
    begin
        result.kind              = kind;
        result.error_code        = (kind == KIND_ERROR) ? err : ERR_MISSING_MARK;
        result.record_length     = (kind == KIND_ERROR) ? '0 : cur_len_reg;
        result.total_length      = len_sum_next;
        result.long_total_length = long_sum_next;
        result.record_count      = rec_cnt_next;
        result.long_record_count = long_cnt_next;
        result.largest_record    = largest_next;
        result.at_total          = at_next;
        result.gc_total          = gc_next;
        result.n_total           = n_next;
    end

    assign res_valid = advance && emit;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MARK;
            cur_len_reg  <= '0;
            len_sum_reg  <= '0;
            long_sum_reg <= '0;
            rec_cnt_reg  <= '0;
            long_cnt_reg <= '0;
            largest_reg  <= '0;
            at_reg       <= '0;
            gc_reg       <= '0;
            n_reg        <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            cur_len_reg  <= cur_len_next;
            len_sum_reg  <= len_sum_next;
            long_sum_reg <= long_sum_next;
            rec_cnt_reg  <= rec_cnt_next;
            long_cnt_reg <= long_cnt_next;
            largest_reg  <= largest_next;
            at_reg       <= at_next;
            gc_reg       <= gc_next;
            n_reg        <= n_next;
        end
    end

    // checks
    assign terminal = (phase_reg == PH_DONE) || (phase_reg == PH_ERROR);

    `ASSERT_NEXT(a_terminal_sticks, clk, rst_n, terminal, phase_reg == $past(phase_reg))
    `ASSERT_IMPLIES(a_terminal_silent, clk, rst_n, terminal, !res_valid)
    `ASSERT_ALWAYS(a_long_le_all, clk, rst_n, long_cnt_reg <= rec_cnt_reg)
    `ASSERT_ALWAYS(a_largest_le_sum, clk, rst_n, largest_reg <= len_sum_reg)
    `ASSERT_NEXT(a_count_monotone, clk, rst_n, 1'b1, rec_cnt_reg >= $past(rec_cnt_reg))

endmodule

// File: design/fsp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module fsp_out_stage
    import fsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  fsp_result_t result_in,
    output logic        slot_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output fsp_result_t result
);

    logic        valid_reg;
    fsp_result_t result_reg;

    // free when empty or draining this cycle
    assign slot_free = !valid_reg || m_tready;

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= load;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load && slot_free)
        begin
            result_reg <= result_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign result   = result_reg;

endmodule

// File: design/fasta_sequence_stats_parser.sv
`timescale 1ns / 1ps
// a byte waits in the input register; the result word it gives waits in the result register
// throughput: one byte per cycle while the result slot is free or draining
// a byte that closes no record and raises no error gives no output word
// reset clears the phase, all totals and the word valid flags; threshold returns to 10000
// ----------------------------------------------------------------------------
// fasta_sequence_stats_parser
// FASTA byte stream parser producing per-record and final assembly totals.
// ----------------------------------------------------------------------------
module fasta_sequence_stats_parser
    import fsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [LENGTH_BITS-1:0] cfg_wdata,  // long_threshold
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,    // data_byte
    input  logic [0:0]             s_tuser,    // op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // error_code, record_length, total_length, long_total_length, record_count,
    // long_record_count, largest_record, at_total, gc_total, n_total, zero pad
    output logic [351:0]           m_tdata,
    output logic [1:0]             m_tuser     // kind
);

    logic [LENGTH_BITS-1:0] threshold_reg;
    fsp_item_t              item_in;
    fsp_item_t              item;
    logic                   item_valid;
    logic                   take;
    logic                   slot_free;
    logic                   res_valid;
    fsp_result_t            res;
    fsp_result_t            out_res;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= LONG_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    assign item_in.op        = s_tuser[0];
    assign item_in.data_byte = s_tdata;

    // core advances when a word is held and the result slot can take it
    assign take = item_valid && slot_free;

    fsp_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .item_in    (item_in),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    fsp_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (take),
        .item           (item),
        .long_threshold (threshold_reg),
        .res_valid      (res_valid),
        .result         (res)
    );

    fsp_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .result_in (res),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (out_res)
    );

    // output packing
    assign m_tuser = out_res.kind;
    assign m_tdata = {
        6'd0,
        out_res.n_total,
        out_res.gc_total,
        out_res.at_total,
        out_res.largest_record,
        out_res.long_record_count,
        out_res.record_count,
        out_res.long_total_length,
        out_res.total_length,
        out_res.record_length,
        out_res.error_code
    };

endmodule

// File: test/fasta_sequence_stats_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_sequence_stats_parser_test
// Feeds one long FASTA byte stream through the parser. A short table of
// directed words comes first, then random well-formed records under several
// long-record thresholds and three idle patterns, then one randomly chosen
// way of ending the file and a tail of words that must be ignored. Every
// result word is checked field by field against a cycle-free model of the
// parser kept in this bench, or against a word typed into the directed table.
// ----------------------------------------------------------------------------
module fasta_sequence_stats_parser_test;
    import fsp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SEGMENT_WORDS = 215;
    localparam int NUM_SEGMENTS = 6;
    localparam int SCRIPT_ROWS = 25;

    localparam logic [1:0] NO_ERROR = 2'd0;

    // ways the stream can end
    localparam int END_EOF = 0;
    localparam int END_EOF_IN_HEADER = 1;
    localparam int END_BAD_BYTE = 2;
    localparam int END_MARK_AFTER_HEADER = 3;
    localparam int END_EOF_IN_LINE = 4;

    typedef struct packed {
        logic        op;
        logic [7:0]  data_byte;
        logic        pinned;
        fsp_result_t word;
    } script_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [LENGTH_BITS-1:0] cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [351:0]           m_tdata;
    logic [1:0]             m_tuser;

    // expectation typed into the directed table, travels with the word
    logic                   pin_flag;
    fsp_result_t            pin_word;

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count = 0;
    int words_accepted = 0;
    int records_seen = 0;
    int last_kind = -1;
    int last_code = -1;
    int unsigned cycle_count = 0;

    fsp_result_t pending_totals [$];
    script_row_t script [0:SCRIPT_ROWS-1];

    logic [7:0] seq_letters [0:9] = '{CH_A_UP, CH_A_LO, CH_T_UP, CH_T_LO, CH_C_UP,
                                      CH_C_LO, CH_G_UP, CH_G_LO, CH_N_UP, CH_N_LO};

    // parser model state
    logic [PHASE_BITS-1:0]  ph;
    logic [LENGTH_BITS-1:0] thr;
    logic [LENGTH_BITS-1:0] cur_len;
    logic [LENGTH_BITS-1:0] len_sum;
    logic [LENGTH_BITS-1:0] long_sum;
    logic [LENGTH_BITS-1:0] big_len;
    logic [LENGTH_BITS-1:0] at_cnt;
    logic [LENGTH_BITS-1:0] gc_cnt;
    logic [LENGTH_BITS-1:0] n_cnt;
    logic [COUNT_BITS-1:0]  rec_cnt;
    logic [COUNT_BITS-1:0]  long_cnt;

    fasta_sequence_stats_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // saturating arithmetic for the model
    function automatic logic [LENGTH_BITS-1:0] add_len_sat(input logic [LENGTH_BITS-1:0] a,
                                                           input logic [LENGTH_BITS-1:0] b);
        logic [LENGTH_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LENGTH_BITS] ? '1 : s[LENGTH_BITS-1:0];
    endfunction

    function automatic logic [LENGTH_BITS-1:0] len_bump(input logic [LENGTH_BITS-1:0] a);
        return (a == '1) ? a : a + LENGTH_BITS'(1);
    endfunction

    function automatic logic [COUNT_BITS-1:0] cnt_bump(input logic [COUNT_BITS-1:0] a);
        return (a == '1) ? a : a + COUNT_BITS'(1);
    endfunction

    // what a byte means inside a sequence line
    function automatic logic [2:0] byte_group(input logic [7:0] b);
        if (b == CH_A_UP || b == CH_A_LO || b == CH_T_UP || b == CH_T_LO)
            return CLS_AT;
        if (b == CH_C_UP || b == CH_C_LO || b == CH_G_UP || b == CH_G_LO)
            return CLS_GC;
        if (b == CH_N_UP || b == CH_N_LO)
            return CLS_N;
        if (b == CH_CR)
            return CLS_CR;
        if (b == CH_LF)
            return CLS_LF;
        return CLS_OTHER;
    endfunction

    function automatic fsp_result_t totals_word(input logic [1:0] kind, input logic [1:0] code,
                                                input logic [LENGTH_BITS-1:0] rl);
        fsp_result_t w;
        w.kind = kind;
        w.error_code = code;
        w.record_length = rl;
        w.total_length = len_sum;
        w.long_total_length = long_sum;
        w.record_count = rec_cnt;
        w.long_record_count = long_cnt;
        w.largest_record = big_len;
        w.at_total = at_cnt;
        w.gc_total = gc_cnt;
        w.n_total = n_cnt;
        return w;
    endfunction

    function automatic fsp_result_t fault_word(input logic [1:0] code);
        ph = PH_ERROR;
        return totals_word(KIND_ERROR, code, '0);
    endfunction

    // fold the open record into the running totals
    function automatic void close_current();
        len_sum = add_len_sat(len_sum, cur_len);
        rec_cnt = cnt_bump(rec_cnt);
        if (cur_len > big_len)
            big_len = cur_len;
        if (cur_len > thr)
        begin
            long_sum = add_len_sat(long_sum, cur_len);
            long_cnt = cnt_bump(long_cnt);
        end
    endfunction

    // one byte of a sequence line, returns 0 on a byte that is not allowed
    function automatic bit take_seq_byte(input logic [7:0] b);
        logic [2:0] grp;
        grp = byte_group(b);
        if (grp == CLS_OTHER)
            return 1'b0;
        if (grp == CLS_CR)
            ph = PH_SEQ;
        else if (grp == CLS_LF)
            ph = PH_AFTER_LF;
        else
        begin
            if (grp == CLS_AT)
                at_cnt = len_bump(at_cnt);
            else if (grp == CLS_GC)
                gc_cnt = len_bump(gc_cnt);
            else
                n_cnt = len_bump(n_cnt);
            cur_len = len_bump(cur_len);
            ph = PH_SEQ;
        end
        return 1'b1;
    endfunction

    // advance the model by one accepted word, returns 1 when a result is due
    function automatic bit parse_fasta_word(input logic op, input logic [7:0] b,
                                            output fsp_result_t w);
        bit eof;
        bit produced;
        eof = (op == OP_EOF);
        produced = 1'b0;
        w = '0;
        case (ph)
            PH_MARK:
                if (eof || b != CH_MARK)
                begin
                    w = fault_word(ERR_MISSING_MARK);
                    produced = 1'b1;
                end
                else
                    ph = PH_HEADER;
            PH_HEADER:
                if (eof)
                begin
                    w = fault_word(ERR_EOF_IN_HEADER);
                    produced = 1'b1;
                end
                else if (b == CH_LF)
                begin
                    cur_len = '0;
                    ph = PH_SEQ;
                end
            PH_SEQ:
                if (eof || !take_seq_byte(b))
                begin
                    w = fault_word(ERR_BAD_CHAR);
                    produced = 1'b1;
                end
            PH_AFTER_LF:
                if (eof)
                begin
                    close_current();
                    ph = PH_DONE;
                    w = totals_word(KIND_EOF, NO_ERROR, cur_len);
                    produced = 1'b1;
                end
                else if (b == CH_MARK)
                begin
                    close_current();
                    ph = PH_HEADER;
                    w = totals_word(KIND_RECORD, NO_ERROR, cur_len);
                    produced = 1'b1;
                end
                else if (!take_seq_byte(b))
                begin
                    w = fault_word(ERR_BAD_CHAR);
                    produced = 1'b1;
                end
            default:
                ;
        endcase
        return produced;
    endfunction

    // record-closed word with the long totals still at zero
    function automatic fsp_result_t closed_word(input int rl, input int tot, input int cnt,
                                                input int big, input int at, input int gc,
                                                input int n);
        fsp_result_t w;
        w = '0;
        w.kind = KIND_RECORD;
        w.error_code = NO_ERROR;
        w.record_length = LENGTH_BITS'(rl);
        w.total_length = LENGTH_BITS'(tot);
        w.record_count = COUNT_BITS'(cnt);
        w.largest_record = LENGTH_BITS'(big);
        w.at_total = LENGTH_BITS'(at);
        w.gc_total = LENGTH_BITS'(gc);
        w.n_total = LENGTH_BITS'(n);
        return w;
    endfunction

    function automatic void cmp_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // send one word, idling first at the current rate
    task automatic send_word(input logic op, input logic [7:0] b, input bit pinned = 1'b0,
                             input fsp_result_t pin = '0);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        pin_flag <= pinned;
        pin_word <= pin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop sending and let every outstanding result drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_totals.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // receiver stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // model update on accepted words, checking on result words
    always @(posedge clk)
    begin : scoreboard
        fsp_result_t predicted;
        fsp_result_t got;
        fsp_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                words_accepted++;
                if (parse_fasta_word(s_tuser[0], s_tdata, predicted))
                    pending_totals.push_back(pin_flag ? pin_word : predicted);
            end
            if (m_tvalid && m_tready)
            begin
                got.kind = m_tuser;
                got.error_code = m_tdata[1:0];
                got.record_length = m_tdata[41:2];
                got.total_length = m_tdata[81:42];
                got.long_total_length = m_tdata[121:82];
                got.record_count = m_tdata[153:122];
                got.long_record_count = m_tdata[185:154];
                got.largest_record = m_tdata[225:186];
                got.at_total = m_tdata[265:226];
                got.gc_total = m_tdata[305:266];
                got.n_total = m_tdata[345:306];
                last_kind = int'(got.kind);
                last_code = int'(got.error_code);
                if (got.kind == KIND_RECORD)
                    records_seen++;
                if (pending_totals.size() == 0)
                begin
                    $display("%0t: result word with none expected, kind %0d, code %0d",
                             $time, got.kind, got.error_code);
                    fail_count++;
                end
                else
                begin
                    want = pending_totals.pop_front();
                    cmp_field("kind", 64'(want.kind), 64'(got.kind));
                    cmp_field("error_code", 64'(want.error_code), 64'(got.error_code));
                    cmp_field("record_length", 64'(want.record_length),
                              64'(got.record_length));
                    cmp_field("total_length", 64'(want.total_length),
                              64'(got.total_length));
                    cmp_field("long_total_length", 64'(want.long_total_length),
                              64'(got.long_total_length));
                    cmp_field("record_count", 64'(want.record_count),
                              64'(got.record_count));
                    cmp_field("long_record_count", 64'(want.long_record_count),
                              64'(got.long_record_count));
                    cmp_field("largest_record", 64'(want.largest_record),
                              64'(got.largest_record));
                    cmp_field("at_total", 64'(want.at_total), 64'(got.at_total));
                    cmp_field("gc_total", 64'(want.gc_total), 64'(got.gc_total));
                    cmp_field("n_total", 64'(want.n_total), 64'(got.n_total));
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time, pending_totals.size());
            $display("fasta_sequence_stats_parser test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int seg;
        int target;
        int how;
        int hdr_len;
        int letters;
        logic [7:0] b;
        logic [LENGTH_BITS-1:0] new_thr;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_BYTE;
        pin_flag <= 1'b0;
        pin_word <= '0;
        send_idle_pct = 33;
        recv_idle_pct = 61;

        ph = PH_MARK;
        thr = LONG_THRESHOLD_RESET;
        cur_len = '0;
        len_sum = '0;
        long_sum = '0;
        big_len = '0;
        at_cnt = '0;
        gc_cnt = '0;
        n_cnt = '0;
        rec_cnt = '0;
        long_cnt = '0;

        // directed words: extreme header bytes, every letter in both cases,
        // carriage return, an empty record, a short record left open
        script = '{
            '{OP_BYTE, CH_MARK, 1'b0, '0},
            '{OP_BYTE, 8'h00,   1'b0, '0},
            '{OP_BYTE, 8'hFF,   1'b0, '0},
            '{OP_BYTE, CH_LF,   1'b0, '0},
            '{OP_BYTE, CH_A_UP, 1'b0, '0},
            '{OP_BYTE, CH_A_LO, 1'b0, '0},
            '{OP_BYTE, CH_T_UP, 1'b0, '0},
            '{OP_BYTE, CH_T_LO, 1'b0, '0},
            '{OP_BYTE, CH_C_UP, 1'b0, '0},
            '{OP_BYTE, CH_C_LO, 1'b0, '0},
            '{OP_BYTE, CH_G_UP, 1'b0, '0},
            '{OP_BYTE, CH_G_LO, 1'b0, '0},
            '{OP_BYTE, CH_N_UP, 1'b0, '0},
            '{OP_BYTE, CH_N_LO, 1'b0, '0},
            '{OP_BYTE, CH_CR,   1'b0, '0},
            '{OP_BYTE, CH_LF,   1'b0, '0},
            '{OP_BYTE, CH_MARK, 1'b1, closed_word(10, 10, 1, 10, 4, 4, 2)},
            '{OP_BYTE, 8'h55,   1'b0, '0},
            '{OP_BYTE, CH_LF,   1'b0, '0},
            '{OP_BYTE, CH_LF,   1'b0, '0},
            '{OP_BYTE, CH_MARK, 1'b1, closed_word(0, 10, 2, 10, 4, 4, 2)},
            '{OP_BYTE, 8'h78,   1'b0, '0},
            '{OP_BYTE, CH_LF,   1'b0, '0},
            '{OP_BYTE, CH_G_UP, 1'b0, '0},
            '{OP_BYTE, CH_LF,   1'b0, '0}
        };

        // reset
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_ROWS; i++)
            send_word(script[i].op, script[i].data_byte, script[i].pinned, script[i].word);

        // random records, one threshold setting per segment
        for (seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            if (seg == 2)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 33;
            end
            else if (seg == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg)
                0: new_thr = '0;
                1: new_thr = '1;
                2: new_thr = LENGTH_BITS'(25);
                3: new_thr = LENGTH_BITS'($urandom_range(0, 60));
                4: new_thr = LENGTH_BITS'(1);
                default: new_thr = LENGTH_BITS'($urandom_range(0, 40));
            endcase

            // threshold write only with the parser idle
            settle();
            cfg_we <= 1'b1;
            cfg_wdata <= new_thr;
            @(posedge clk);
            cfg_we <= 1'b0;
            thr = new_thr;

            target = words_accepted + SEGMENT_WORDS;
            while (words_accepted < target)
            begin
                // header of random bytes, any value but line feed
                send_word(OP_BYTE, CH_MARK);
                hdr_len = $urandom_range(0, 10);
                repeat (hdr_len)
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_LF);
                    send_word(OP_BYTE, b);
                end
                send_word(OP_BYTE, CH_LF);
                // sequence lines, some empty, some with carriage returns
                repeat ($urandom_range(1, 3))
                begin
                    letters = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
                    repeat (letters)
                    begin
                        if ($urandom_range(0, 19) == 0)
                            send_word(OP_BYTE, CH_CR);
                        send_word(OP_BYTE, seq_letters[4'($urandom_range(0, 9))]);
                    end
                    if ($urandom_range(0, 3) == 0)
                        send_word(OP_BYTE, CH_CR);
                    send_word(OP_BYTE, CH_LF);
                end
            end
        end

        // the parser locks after its first end or error, so pick one ending
        how = $urandom_range(END_EOF, END_EOF_IN_LINE);
        if (how != END_EOF)
        begin
            send_word(OP_BYTE, CH_MARK);
            send_word(OP_BYTE, 8'h68);
            if (how != END_EOF_IN_HEADER)
                send_word(OP_BYTE, CH_LF);
            if (how == END_BAD_BYTE || how == END_EOF_IN_LINE)
                repeat ($urandom_range(1, 5))
                    send_word(OP_BYTE, seq_letters[4'($urandom_range(0, 9))]);
        end
        case (how)
            END_BAD_BYTE:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (byte_group(b) != CLS_OTHER);
                send_word(OP_BYTE, b);
            end
            END_MARK_AFTER_HEADER:
                send_word(OP_BYTE, CH_MARK);
            default:
                send_word(OP_EOF, 8'($urandom_range(0, 255)));
        endcase

        // words after the end must give nothing
        repeat (20)
            send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

        settle();

        $display("covered %0d words over %0d threshold settings, %0d records closed",
                 words_accepted, NUM_SEGMENTS + 1, records_seen);
        $display("stream ending %0d, last result kind %0d with code %0d",
                 how, last_kind, last_code);
        if (fail_count == 0)
            $display("fasta_sequence_stats_parser test passed");
        else
            $display("fasta_sequence_stats_parser test failed");
        $finish;
    end

endmodule

// File: fasta_sequence_stats_parser.f
+incdir+design
design/fsp_pkg.sv
design/fsp_in_stage.sv
design/fsp_core.sv
design/fsp_out_stage.sv
design/fasta_sequence_stats_parser.sv
test/fasta_sequence_stats_parser_test.sv
